### sv/lcgug_pkg.sv
// shared types, constants and helpers for the lcg uniform / gaussian generator
// no dependencies; imported by every module of the block

package lcgug_pkg;

    // seed and fixed-point layout
    localparam int SEED_W     = 20;
    localparam int FRAC_BITS  = 20;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 24;   // holds twelve 20-bit seeds
    localparam int OPA_W      = 33;   // upper - lower, or sigma sign extended
    localparam int OPB_W      = 25;   // seed, or centered sum
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int SCALED_W   = PROD_W - FRAC_BITS;
    localparam int RES_W      = 40;   // mean plus scaled product, room for overflow
    localparam int STEP_CNT_W = 4;

    localparam logic [10:0] LCG_MUL = 11'd2045;
    localparam logic [STEP_CNT_W-1:0] GAUSS_TERMS = 4'd12;
    localparam logic [STEP_CNT_W-1:0] UNIFORM_TERMS = 4'd1;
    localparam logic signed [OPB_W-1:0] GAUSS_OFFSET = 25'sd6291456; // 6 * 2^20

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // request codes
    localparam logic [1:0] REQ_UNIFORM = 2'd0;
    localparam logic [1:0] REQ_GAUSS   = 2'd1;
    localparam logic [1:0] REQ_LOAD    = 2'd2;

    // input transaction
    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] lower_or_mean;
        logic signed [DATA_W-1:0] upper_or_sigma;
        logic [SEED_W-1:0]        seed_load_value;
    } t_req_item;

    // output transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] draw_value;
        logic                     saturated;
        logic [SEED_W-1:0]        seed_after;
    } t_result_item;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_MUL,
        S_FIN
    } t_state_e;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic mult;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // one generator step: (2045 * s + 1) mod 2^20
    function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] s);
        logic [30:0] p;
        p = 31'(s) * 31'(LCG_MUL) + 31'd1;
        return p[SEED_W-1:0];
    endfunction

endpackage

### sv/lcgug_ctrl.sv
// controller state machine: sequences capture, seed steps, multiply and result write
// depends on lcgug_pkg

module lcgug_ctrl import lcgug_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state_e               r_state, n_state;
    logic [STEP_CNT_W-1:0]  r_cnt, n_cnt;
    logic                   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // state and step counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_UNIFORM) begin
                        n_state = S_STEP;
                        n_cnt   = UNIFORM_TERMS - 4'd1;
                    end else if (i_req_type == REQ_GAUSS) begin
                        n_state = S_STEP;
                        n_cnt   = GAUSS_TERMS - 4'd1;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_STEP: begin
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            S_MUL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.capture = w_accept;
        o_cmd.step    = (r_state == S_STEP);
        o_cmd.mult    = (r_state == S_MUL);
        o_cmd.emit    = (r_state == S_FIN) && i_status.out_free;
    end

endmodule

### sv/lcgug_datapath.sv
// datapath: seed register, sum accumulator, shared multiplier, scaling and output register
// depends on lcgug_pkg

module lcgug_datapath import lcgug_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_req_item    i_req,
    input  t_dp_cmd      i_cmd,
    input  logic         i_out_ready,
    output t_dp_status   o_status,
    output logic         o_out_valid,
    output t_result_item o_result
);

    logic [SEED_W-1:0]        r_seed;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic [1:0]               r_req;
    logic [SUM_W-1:0]         r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;
    t_result_item             r_out;

    logic [SEED_W-1:0]          w_next;
    logic signed [OPA_W-1:0]    w_op_a;
    logic signed [OPB_W-1:0]    w_op_b;
    logic signed [PROD_W-1:0]   w_shift;
    logic signed [SCALED_W-1:0] w_scaled;
    logic signed [RES_W-1:0]    w_total;
    logic                       w_ovf;
    t_result_item               w_res;

    assign w_next = lcg_next(r_seed);

    // seed, operands and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cmd.capture) begin
            if (i_req.req_type == REQ_LOAD) begin
                r_seed <= i_req.seed_load_value;
            end
        end else if (i_cmd.step) begin
            r_seed <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a   <= i_req.lower_or_mean;
            r_b   <= i_req.upper_or_sigma;
            r_req <= i_req.req_type;
            r_sum <= '0;
        end else if (i_cmd.step) begin
            r_sum <= r_sum + SUM_W'(w_next);
        end
    end

    // multiplier operand select
    always_comb begin
        if (r_req == REQ_GAUSS) begin
            w_op_a = {r_b[DATA_W-1], r_b};
            w_op_b = $signed({1'b0, r_sum}) - GAUSS_OFFSET;
        end else begin
            w_op_a = {r_b[DATA_W-1], r_b} - {r_a[DATA_W-1], r_a};
            w_op_b = $signed({{(OPB_W-SEED_W){1'b0}}, r_seed});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= w_op_a * w_op_b;
        end
    end

    // floor shift, add offset, clip gaussian overflow
    always_comb begin
        w_shift  = r_prod >>> FRAC_BITS;
        w_scaled = w_shift[SCALED_W-1:0];
        w_total  = {{(RES_W-DATA_W){r_a[DATA_W-1]}}, r_a}
                 + {{(RES_W-SCALED_W){w_scaled[SCALED_W-1]}}, w_scaled};
        w_ovf    = (w_total[RES_W-1:DATA_W-1] != '0) && (w_total[RES_W-1:DATA_W-1] != '1);
        w_res.seed_after = r_seed;
        w_res.saturated  = 1'b0;
        w_res.draw_value = '0;
        if (r_req == REQ_GAUSS) begin
            w_res.saturated = w_ovf;
            if (w_ovf) begin
                w_res.draw_value = w_total[RES_W-1] ? Q_MIN : Q_MAX;
            end else begin
                w_res.draw_value = w_total[DATA_W-1:0];
            end
        end else if (r_req == REQ_UNIFORM) begin
            w_res.draw_value = w_total[DATA_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= w_res;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_out;

endmodule

### sv/lcg_uniform_gaussian_generator.sv
// top level of the lcg uniform / gaussian generator: controller plus datapath
// depends on lcgug_pkg, lcgug_ctrl, lcgug_datapath
//
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_in_req   (t_req_item)
// result    out        o_out_valid / i_out_ready  o_out_result (t_result_item)
//
// one request at a time; a uniform draw runs accept, one seed step, multiply and scale,
// a gaussian draw the same with twelve seed steps through one lcg stage, and a seed
// load goes from accept straight to the result write; each returns to idle before the next accept.
// reset clears the seed to zero and empties the output register.
// a new request is taken while a result waits on a stalled output; the next
// result holds in the final stage until the output register frees up.

module lcg_uniform_gaussian_generator import lcgug_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_req_item    i_in_req,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_result_item o_out_result
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing
    lcgug_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_req.req_type),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    lcgug_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_result    (o_out_result)
    );

endmodule

### sv/lcgug_checker.sv
// port-level checker for the lcg uniform / gaussian generator, bound to the top level
// depends on lcgug_pkg

module lcgug_checker import lcgug_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         o_in_ready,
    input t_req_item    i_in_req,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input t_result_item o_out_result
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_result))
        else $error("result changed while stalled");

    // only one request in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    // a clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_result.saturated |->
            (o_out_result.draw_value == Q_MAX) || (o_out_result.draw_value == Q_MIN))
        else $error("saturated result not at a limit");

    // a seed load into an empty output shows the new seed and zero after the final state and the output register
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid && (i_in_req.req_type == REQ_LOAD)
        |=> ##1 o_out_valid && (o_out_result.draw_value == '0)
            && (o_out_result.seed_after == $past(i_in_req.seed_load_value, 2)))
        else $error("seed load result wrong");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind lcg_uniform_gaussian_generator lcgug_checker u_lcgug_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_in_req     (i_in_req),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_result (o_out_result)
);

### tb/sv/lcg_uniform_gaussian_generator_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for lcg_uniform_gaussian_generator: directed and random requests
// depends on lcgug_pkg and the generator rtl; a tracker class predicts every draw

module lcg_uniform_gaussian_generator_tb;
    import lcgug_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    // tracks the generator seed and the draws still owed by the block
    class lcg_draw_tracker;
        logic [SEED_W-1:0] model_seed;
        t_result_item expected_draws[$];
        int mismatches;

        function new();
            model_seed = '0;
            mismatches = 0;
        endfunction

        function logic [SEED_W-1:0] advance_seed(input logic [SEED_W-1:0] s);
            logic [39:0] prod;
            prod = 40'(s) * 40'd2045 + 40'd1;
            return prod[SEED_W-1:0];
        endfunction

        // predict the draw for one accepted request transaction
        function void note_request(input t_req_item req);
            t_result_item draw;
            longint lo;
            longint hi;
            longint acc;
            longint total;
            draw = '0;
            lo = longint'($signed(req.lower_or_mean));
            hi = longint'($signed(req.upper_or_sigma));
            case (req.req_type)
                REQ_UNIFORM: begin
                    model_seed = advance_seed(model_seed);
                    total = lo + (((hi - lo) * longint'(model_seed)) >>> FRAC_BITS);
                    draw.draw_value = 32'(total);
                end
                REQ_GAUSS: begin
                    acc = 0;
                    for (int k = 0; k < int'(GAUSS_TERMS); k++) begin
                        model_seed = advance_seed(model_seed);
                        acc += longint'(model_seed);
                    end
                    acc -= longint'(GAUSS_OFFSET);
                    total = lo + ((acc * hi) >>> FRAC_BITS);
                    // clip to the q15.16 range
                    if (total > longint'(Q_MAX)) begin
                        total = longint'(Q_MAX);
                        draw.saturated = 1'b1;
                    end else if (total < longint'(Q_MIN)) begin
                        total = longint'(Q_MIN);
                        draw.saturated = 1'b1;
                    end
                    draw.draw_value = 32'(total);
                end
                REQ_LOAD: begin
                    model_seed = req.seed_load_value;
                end
                default: begin
                    // unused code leaves the seed alone
                end
            endcase
            draw.seed_after = model_seed;
            expected_draws.push_back(draw);
        endfunction

        function void report(input string what, input longint want, input longint got);
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want,
                got);
        endfunction

        // compare one accepted result transaction with the oldest prediction
        function void check_result(input t_result_item got);
            t_result_item want;
            if (expected_draws.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_draws.pop_front();
            if (got.draw_value !== want.draw_value)
                report("draw_value", longint'($signed(want.draw_value)),
                    longint'($signed(got.draw_value)));
            if (got.saturated !== want.saturated)
                report("saturated", longint'(want.saturated), longint'(got.saturated));
            if (got.seed_after !== want.seed_after)
                report("seed_after", longint'(want.seed_after), longint'(got.seed_after));
        endfunction

        function int outstanding();
            return expected_draws.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         req_valid = 1'b0;
    logic         req_ready;
    t_req_item    req_item = '0;
    logic         res_valid;
    logic         res_ready = 1'b0;
    t_result_item res_item;

    int unsigned  idle_pct = 25;
    int unsigned  cycle_count = 0;
    lcg_draw_tracker draws = new();

    lcg_uniform_gaussian_generator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (req_valid),
        .o_in_ready   (req_ready),
        .i_in_req     (req_item),
        .o_out_valid  (res_valid),
        .i_out_ready  (res_ready),
        .o_out_result (res_item)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_valid && res_ready)
                draws.check_result(res_item);
            if (req_valid && req_ready)
                draws.note_request(req_item);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lcg_uniform_gaussian_generator regression: fail");
            $finish;
        end
    end

    // result side: random stall bursts while idling is on
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            res_ready <= 1'b1;
        end
    end

    function automatic t_req_item req_of(input logic [1:0] kind,
                                         input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b,
                                         input logic [SEED_W-1:0] s);
        t_req_item item;
        item.req_type = kind;
        item.lower_or_mean = a;
        item.upper_or_sigma = b;
        item.seed_load_value = s;
        return item;
    endfunction

    // operand mix: limits, zero, one, small magnitudes and full range
    function automatic logic signed [DATA_W-1:0] pick_q();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            4, 5: return 32'($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
            default: return 32'($urandom);
        endcase
    endfunction

    // present one request transaction from a falling edge until it is taken,
    // then maybe hold valid low for a burst
    task automatic send_request(input t_req_item item);
        req_valid <= 1'b1;
        req_item <= item;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    // stimulus
    initial begin
        int kind;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: bounds, reversed bounds, saturation both ways, loads, unused code
        send_request(req_of(REQ_UNIFORM, '0, Q_ONE, 20'h12345));
        send_request(req_of(REQ_UNIFORM, Q_MIN, Q_MAX, '0));
        send_request(req_of(REQ_UNIFORM, Q_MAX, Q_MIN, '0));
        send_request(req_of(REQ_UNIFORM, Q_ONE, Q_ONE, '0));
        send_request(req_of(REQ_GAUSS, '0, Q_ONE, '0));
        send_request(req_of(REQ_GAUSS, Q_MAX, Q_MAX, '0));
        send_request(req_of(REQ_GAUSS, Q_MAX, Q_MIN, '0));
        send_request(req_of(REQ_GAUSS, Q_MIN, Q_MAX, '0));
        send_request(req_of(REQ_GAUSS, Q_MIN, Q_MIN, '0));
        send_request(req_of(REQ_GAUSS, Q_ONE, -Q_ONE, '0));
        send_request(req_of(REQ_GAUSS, '0, '0, 20'hFFFFF));
        send_request(req_of(REQ_LOAD, Q_MAX, Q_MIN, '0));
        send_request(req_of(REQ_UNIFORM, '0, Q_MAX, '0));
        send_request(req_of(REQ_LOAD, Q_MIN, Q_MAX, 20'hFFFFF));
        send_request(req_of(REQ_GAUSS, '0, Q_ONE, '0));
        send_request(req_of(REQ_LOAD, '0, '0, 20'h5A5A5));
        send_request(req_of(REQ_UNUSED, Q_MAX, Q_MIN, 20'hA5A5A));
        send_request(req_of(REQ_UNIFORM, Q_MIN, '0, '0));
        send_request(req_of(REQ_UNUSED, '0, '0, 20'hFFFFF));
        send_request(req_of(REQ_GAUSS, Q_MAX, Q_ONE, 20'h00001));

        // random: bursty, then quiet, then heavy, quiet tail
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                idle_pct = 0;
            else if (n == 450)
                idle_pct = 50;
            else if (n == 750)
                idle_pct = 0;
            kind = $urandom_range(0, 19);
            send_request(req_of(kind < 7 ? REQ_UNIFORM : kind < 14 ? REQ_GAUSS :
                                kind < 18 ? REQ_LOAD : REQ_UNUSED,
                                pick_q(), pick_q(), 20'($urandom_range(0, 20'hFFFFF))));
        end
        req_valid <= 1'b0;

        // drain outstanding draws, then watch for strays
        while (draws.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (draws.mismatches == 0 && draws.outstanding() == 0)
            $display("lcg_uniform_gaussian_generator regression: pass");
        else
            $display("lcg_uniform_gaussian_generator regression: fail");
        $finish;
    end

endmodule
